@@ src/spq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the sorted priority queue.
package spq_pkg;

    // Default number of queue slots
    localparam int SPQ_DEPTH = 16;

    // Field widths
    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Stream word widths, padded to whole bytes
    localparam int IN_RAW_W  = OP_W + 2 * DATA_W;
    localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = STATUS_W + DATA_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;     // latch the input transfer and set up pointers
        logic head_capture;  // take the head slot read, pop it on a remove
        logic scan;          // one insertion step toward the head
        logic place;         // write the new entry at the write pointer
        logic emit;          // move the result into the output register
    } t_spq_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] in_op;  // opcode of the offered input transfer
        logic            empty;
        logic            full;
        logic            found;  // slot read outranks the new entry
        logic            last;   // one unexamined entry left
        logic            out_free;
    } t_spq_sts;

endpackage

@@ src/sorted_priority_queue.sv @@
// Sorted priority queue: highest priority at the head, entries held in a ring buffer memory.
// Steps: peek and remove read the head slot, then register the result; full, empty and unused
// codes register the result directly; insert walks back from the tail, shifting each entry of
// lower or equal priority, then writes the new entry. One operation is in flight; the next is
// accepted the cycle after its result is registered, and a result waits while the output stalls.
// Reset (synchronous, active low) empties the queue; the slot memory itself is not cleared.
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // fields from bit 0: opcode[2], item_value[32], item_priority[32], zero pad
    input  logic [spq_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fields from bit 0: status[2], head_value[32], entry_count[5], zero pad
    output logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import spq_pkg::*;

    t_spq_cmd cmd;
    t_spq_sts sts;

    spq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    spq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .i_cmd    (cmd),
        .o_sts    (sts)
    );

endmodule

@@ src/spq_ctrl.sv @@
// Controller state machine that sequences each queue operation.
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  spq_pkg::t_spq_sts i_sts,
    output spq_pkg::t_spq_cmd o_cmd
);
    import spq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Decode state into commands and pick the next state
    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    unique case (i_sts.in_op) inside
                        OP_INSERT: begin
                            if (i_sts.full) begin
                                n_state = S_DONE;
                            end else if (i_sts.empty) begin
                                n_state = S_PLACE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_REMOVE, OP_PEEK: begin
                            n_state = i_sts.empty ? S_DONE : S_HEAD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                o_cmd.head_capture = 1'b1;
                n_state = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found) begin
                    n_state = S_DONE;
                end else if (i_sts.last) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/spq_dpath.sv @@
// Datapath: slot memory kept as a ring, pointers, count and the output register.
module spq_dpath #(
    parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [spq_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [spq_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  spq_pkg::t_spq_cmd                  i_cmd,
    output spq_pkg::t_spq_sts                  o_sts
);
    import spq_pkg::*;

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int SLOT_W = 2 * DATA_W;
    localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(QUEUE_DEPTH);

    // Slot memory: priority in the upper half, value in the lower half
    logic [SLOT_W-1:0] r_mem [QUEUE_DEPTH];
    logic [SLOT_W-1:0] r_rd_data;

    logic [ADDR_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_remain;
    logic [ADDR_W-1:0] r_rd_ptr;
    logic [ADDR_W-1:0] r_wr_ptr;
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_pri;
    logic [STATUS_W-1:0] r_res_status;
    logic [DATA_W-1:0] r_res_value;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [OP_W-1:0]   in_op;
    logic [DATA_W-1:0] in_val;
    logic [DATA_W-1:0] in_pri;
    logic [SUM_W-1:0]  tail_sum;
    logic [ADDR_W-1:0] tail_pos;
    logic [ADDR_W-1:0] last_pos;
    logic [ADDR_W-1:0] rd_prev;
    logic [ADDR_W-1:0] head_next;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SLOT_W-1:0] wr_data;
    logic              is_empty;
    logic              is_full;
    logic              found;
    logic [31:0]       count_ext;

    assign in_op  = s_tdata[OP_W-1:0];
    assign in_val = s_tdata[OP_W +: DATA_W];
    assign in_pri = s_tdata[OP_W + DATA_W +: DATA_W];

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= DEPTH_C);
    assign found    = $signed(r_rd_data[SLOT_W-1:DATA_W]) > $signed(r_pri);

    // Ring position arithmetic
    always_comb begin
        tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
        tail_pos  = (tail_sum >= DEPTH_S) ? ADDR_W'(tail_sum - DEPTH_S) : ADDR_W'(tail_sum);
        last_pos  = (tail_pos == '0) ? ADDR_MAX : tail_pos - 1'b1;
        rd_prev   = (r_rd_ptr == '0) ? ADDR_MAX : r_rd_ptr - 1'b1;
        head_next = (r_head == ADDR_MAX) ? '0 : r_head + 1'b1;
    end

    // Select read address: tail on insert, head on remove or peek, walk back while scanning
    always_comb begin
        if (i_cmd.load_item) begin
            rd_addr = (in_op == OP_INSERT) ? last_pos : r_head;
        end else if (i_cmd.scan) begin
            rd_addr = rd_prev;
        end else begin
            rd_addr = r_rd_ptr;
        end
    end

    // Write either the new entry or the shifted slot
    always_comb begin
        wr_en   = i_cmd.scan || i_cmd.place;
        wr_addr = r_wr_ptr;
        if (i_cmd.scan && !found) begin
            wr_data = r_rd_data;
        end else begin
            wr_data = {r_pri, r_val};
        end
    end

    // Slot memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Item, pointer and result registers
    always_ff @(posedge i_clk) begin
        r_rd_ptr <= rd_addr;
        if (i_cmd.load_item) begin
            r_op        <= in_op;
            r_val       <= in_val;
            r_pri       <= in_pri;
            r_wr_ptr    <= tail_pos;
            r_remain    <= r_count;
            r_res_value <= '0;
            unique case (in_op) inside
                OP_INSERT: r_res_status <= is_full ? ST_FULL : ST_OK;
                OP_REMOVE, OP_PEEK: r_res_status <= is_empty ? ST_EMPTY : ST_OK;
                default: r_res_status <= ST_OK;
            endcase
        end
        if (i_cmd.scan && !found) begin
            r_wr_ptr <= r_rd_ptr;
            r_remain <= r_remain - 1'b1;
        end
        if (i_cmd.head_capture) begin
            r_res_value <= r_rd_data[DATA_W-1:0];
        end
    end

    // Head pointer and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if ((i_cmd.scan && found) || i_cmd.place) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.head_capture && r_op == OP_REMOVE) begin
            r_head  <= head_next;
            r_count <= r_count - 1'b1;
        end
    end

    assign count_ext = 32'(r_count);

    // Output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= OUT_TDATA_W'({count_ext[COUNT_W-1:0], r_res_value, r_res_status});
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // Status toward the controller
    always_comb begin
        o_sts.in_op    = in_op;
        o_sts.empty    = is_empty;
        o_sts.full     = is_full;
        o_sts.found    = found;
        o_sts.last     = (r_remain == CNT_W'(1));
        o_sts.out_free = !r_out_valid || m_tready;
    end

endmodule

@@ test/sorted_priority_queue_test.sv @@
// Self-checking testbench for the sorted priority queue: stream driver, monitor and queue predictor.
module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = SPQ_DEPTH;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 365;
    localparam int MAX_REPORTS  = 10;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DATA_W-1:0] item_value;
        logic [DATA_W-1:0] item_prio;
    } t_queue_op;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   head_value;
        logic [COUNT_W-1:0]  entry_count;
    } t_queue_result;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // fields from bit 0: opcode[2], item_value[32], item_priority[32], zero pad
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // fields from bit 0: status[2], head_value[32], entry_count[5], zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Queue contents as the block should hold them, head in slot 0
    logic signed [DATA_W-1:0] held_value [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] held_prio  [QUEUE_DEPTH];
    int                       held_count = 0;

    t_queue_op     pending_ops[$];
    t_queue_result awaited_results[$];
    t_queue_op     offered_op = '0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_active    = 1'b0;
    event hold_go;
    int   error_count    = 0;
    int   cycle_count    = 0;

    sorted_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock, 20 time units per period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one operation to the held queue and return the result it must produce
    function automatic t_queue_result apply_queue_op(t_queue_op op);
        t_queue_result res;
        int            pos;
        res = '0;
        res.status = ST_OK;
        if (op.opcode == OP_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // skip entries of strictly higher priority; equal ones go behind the new entry
                pos = 0;
                while (pos < held_count && held_prio[pos] > $signed(op.item_prio)) begin
                    pos++;
                end
                for (int k = held_count; k > pos; k--) begin
                    held_value[k] = held_value[k-1];
                    held_prio[k]  = held_prio[k-1];
                end
                held_value[pos] = op.item_value;
                held_prio[pos]  = op.item_prio;
                held_count++;
            end
        end else if (op.opcode == OP_REMOVE || op.opcode == OP_PEEK) begin
            if (held_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.head_value = held_value[0];
                if (op.opcode == OP_REMOVE) begin
                    for (int k = 0; k + 1 < held_count; k++) begin
                        held_value[k] = held_value[k+1];
                        held_prio[k]  = held_prio[k+1];
                    end
                    held_count--;
                end
            end
        end
        res.entry_count = held_count[COUNT_W-1:0];
        return res;
    endfunction

    // Count an error; print only the first few
    function automatic void note_error(string what, logic [DATA_W-1:0] exp_v,
                                       logic [DATA_W-1:0] act_v);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR at cycle %0d: %s expected %0h got %0h",
                     cycle_count, what, exp_v, act_v);
        end
    endfunction

    // Draw a random priority: ties from a narrow band, extremes, or the full range
    function automatic logic [DATA_W-1:0] random_prio();
        int pick;
        pick = $urandom_range(5);
        case (pick)
            0, 1: begin
                return DATA_W'($signed($urandom_range(4)) - 2);
            end
            2: begin
                pick = $urandom_range(2);
                return (pick == 0) ? 32'h7fff_ffff : (pick == 1) ? 32'h8000_0000 : 32'h0;
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    // Draw a random operation; insert_pct weights inserts against removes and peeks
    function automatic t_queue_op random_op(int insert_pct);
        t_queue_op op;
        int        roll;
        op.item_value = $urandom();
        op.item_prio  = random_prio();
        roll = $urandom_range(99);
        if (roll < 3) begin
            op.opcode = OP_UNUSED;
        end else if (roll < 3 + insert_pct) begin
            op.opcode = OP_INSERT;
        end else begin
            op.opcode = ($urandom_range(9) < 7) ? OP_REMOVE : OP_PEEK;
        end
        return op;
    endfunction

    task automatic push_op(logic [OP_W-1:0] opc, logic [DATA_W-1:0] val,
                           logic [DATA_W-1:0] prio);
        t_queue_op op;
        op.opcode     = opc;
        op.item_value = val;
        op.item_prio  = prio;
        pending_ops.push_back(op);
    endtask

    // Queue bursts that fill, drain or churn the queue until n operations are queued
    task automatic push_random(int n);
        int queued;
        int burst;
        int bias;
        queued = 0;
        while (queued < n) begin
            case ($urandom_range(2))
                0:       bias = 85;
                1:       bias = 15;
                default: bias = 50;
            endcase
            burst = $urandom_range(8, 40);
            for (int k = 0; k < burst && queued < n; k++) begin
                pending_ops.push_back(random_op(bias));
                queued++;
            end
        end
    endtask

    // Wait until every operation is transferred and every result has come back
    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_tvalid || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: predict on each input transfer, then offer the next pending operation
    always @(posedge i_clk) begin
        t_queue_op next_op;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(apply_queue_op(offered_op));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_op = pending_ops.pop_front();
                    offered_op <= next_op;
                    s_tdata <= {{(IN_TDATA_W - IN_RAW_W){1'b0}},
                                next_op.item_prio, next_op.item_value, next_op.opcode};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, forced low during a hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold-off: keep the receiver stalled after each hold_go event
    always begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Monitor: compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_queue_result exp_res;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                note_error("unexpected result, tdata", '0, m_tdata[DATA_W-1:0]);
            end else begin
                exp_res = awaited_results.pop_front();
                if (m_tdata[STATUS_W-1:0] !== exp_res.status) begin
                    note_error("status", exp_res.status, m_tdata[STATUS_W-1:0]);
                end
                if (m_tdata[STATUS_W +: DATA_W] !== exp_res.head_value) begin
                    note_error("head_value", exp_res.head_value, m_tdata[STATUS_W +: DATA_W]);
                end
                if (m_tdata[STATUS_W + DATA_W +: COUNT_W] !== exp_res.entry_count) begin
                    note_error("entry_count", exp_res.entry_count,
                               m_tdata[STATUS_W + DATA_W +: COUNT_W]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int send_phase [4];
        int recv_phase [4];
        send_phase = '{0, 50, 0, 37};
        recv_phase = '{0, 0, 50, 37};

        // hold reset low, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty queue, unused code, priority and value extremes, ties
        push_op(OP_REMOVE, 32'h1234_5678, 32'h0);
        push_op(OP_PEEK,   32'hffff_ffff, 32'hffff_ffff);
        push_op(OP_UNUSED, 32'hdead_beef, 32'h7fff_ffff);
        push_op(OP_INSERT, 32'h7fff_ffff, 32'h0);
        push_op(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        push_op(OP_INSERT, 32'hffff_ffff, 32'h8000_0000);
        push_op(OP_INSERT, 32'h0,         32'h0);
        push_op(OP_PEEK,   32'h0,         32'h0);
        push_op(OP_REMOVE, 32'h0,         32'h0);
        push_op(OP_REMOVE, 32'h0,         32'h0);
        // fill to the top with ties at both extremes, then overflow once
        for (int k = 0; k < QUEUE_DEPTH - 2; k++) begin
            case (k % 4)
                0:       push_op(OP_INSERT, $urandom(), 32'h7fff_ffff);
                1:       push_op(OP_INSERT, $urandom(), 32'h8000_0000);
                2:       push_op(OP_INSERT, $urandom(), DATA_W'(k % 3));
                default: push_op(OP_INSERT, $urandom(), $urandom());
            endcase
        end
        push_op(OP_INSERT, 32'h5a5a_5a5a, 32'h7fff_ffff);
        wait_drained();

        // back-pressure: stall the receiver while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        for (int k = 0; k < 60; k++) begin
            pending_ops.push_back(random_op(70));
        end
        wait_drained();

        // random phases with different idle and stall rates
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_phase[p];
            recv_stall_pct = recv_phase[p];
            push_random(PHASE_ITEMS);
            wait_drained();
        end

        // let any late output show up
        repeat (QUEUE_DEPTH + 8) @(posedge i_clk);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sorted_priority_queue.f @@
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_dpath.sv
src/sorted_priority_queue.sv
test/sorted_priority_queue_test.sv
